// ===== sv/npc_pkg.sv =====
// Shared types and constants for the nearest palette color unit.
`default_nettype none
package npc_pkg;

  // Hardware search limit on palette entries.
  localparam int unsigned PALETTE_ENTRIES_DEF = 8;

  // Field widths.
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned PAIR_W   = 48;
  localparam int unsigned NUM_PAIRS = 4;

  // APB port geometry: five registers at 8-byte spacing.
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_COUNT  = 3'd0;
  localparam logic [2:0] REG_PAIR_0 = 3'd1;
  localparam logic [2:0] REG_PAIR_1 = 3'd2;
  localparam logic [2:0] REG_PAIR_2 = 3'd3;
  localparam logic [2:0] REG_PAIR_3 = 3'd4;

  // One palette color, red in the top byte and blue in the bottom byte.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    color_t             pixel;
    logic [DIST_W-1:0]  best_dist;
    color_t             color;
    logic [IDX_W-1:0]   idx;
  } carry_t;

endpackage
`default_nettype wire

// ===== sv/npc_regs.sv =====
// APB register file holding the palette count and the packed palette entries.
`default_nettype none
module npc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [npc_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [npc_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [npc_pkg::PDATA_W-1:0]   prdata_o,
  output logic                          pready_o,
  output logic [npc_pkg::COUNT_W-1:0]   count_o,
  output npc_pkg::color_t               palette_o [8]
);
  import npc_pkg::*;

  logic [COUNT_W-1:0] count_q;
  logic [PAIR_W-1:0]  pair_q [NUM_PAIRS];
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx  = paddr_i[5:3];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  // Write the addressed register on the access cycle of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_q[p] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_COUNT:  count_q   <= pwdata_i[COUNT_W-1:0];
        REG_PAIR_0: pair_q[0] <= pwdata_i[PAIR_W-1:0];
        REG_PAIR_1: pair_q[1] <= pwdata_i[PAIR_W-1:0];
        REG_PAIR_2: pair_q[2] <= pwdata_i[PAIR_W-1:0];
        REG_PAIR_3: pair_q[3] <= pwdata_i[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register on reads.
  always_comb begin
    case (reg_idx)
      REG_COUNT:  prdata_o = {{(PDATA_W-COUNT_W){1'b0}}, count_q};
      REG_PAIR_0: prdata_o = {{(PDATA_W-PAIR_W){1'b0}}, pair_q[0]};
      REG_PAIR_1: prdata_o = {{(PDATA_W-PAIR_W){1'b0}}, pair_q[1]};
      REG_PAIR_2: prdata_o = {{(PDATA_W-PAIR_W){1'b0}}, pair_q[2]};
      REG_PAIR_3: prdata_o = {{(PDATA_W-PAIR_W){1'b0}}, pair_q[3]};
      default:    prdata_o = '0;
    endcase
  end

  assign count_o = count_q;

  // Unpack two entries per pair, even entry in the low half.
  for (genvar e = 0; e < 8; e++) begin : g_unpack
    assign palette_o[e] = pair_q[e/2][(e%2)*24 +: 24];
  end

endmodule
`default_nettype wire

// ===== sv/npc_cell.sv =====
// One search cell: scores its own palette entry against the pixel it is handed.
`default_nettype none
module npc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_i,
  input  npc_pkg::color_t color_i,
  input  logic            valid_i,
  input  npc_pkg::carry_t carry_i,
  output logic            valid_o,
  output npc_pkg::carry_t carry_o
);
  import npc_pkg::*;

  localparam bit               FIRST    = (IDX == 0);
  localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(IDX);

  logic [CHAN_W-1:0]   db, dg, dr;
  logic [2*CHAN_W-1:0] sb, sg, sr;
  logic [DIST_W-1:0]   cand_dist;
  logic                take;
  logic                valid_q;
  carry_t              carry_d, carry_q;

  // Square the channel differences and sum them.
  always_comb begin
    db = (carry_i.pixel.blue  > color_i.blue)  ? carry_i.pixel.blue  - color_i.blue
                                               : color_i.blue  - carry_i.pixel.blue;
    dg = (carry_i.pixel.green > color_i.green) ? carry_i.pixel.green - color_i.green
                                               : color_i.green - carry_i.pixel.green;
    dr = (carry_i.pixel.red   > color_i.red)   ? carry_i.pixel.red   - color_i.red
                                               : color_i.red   - carry_i.pixel.red;
    sb = db * db;
    sg = dg * dg;
    sr = dr * dr;
    cand_dist = DIST_W'(sb) + DIST_W'(sg) + DIST_W'(sr);
  end

  // Replace the running best only on a strictly smaller distance; the first cell always takes its entry.
  always_comb begin
    take = active_i && (FIRST || (cand_dist < carry_i.best_dist));
    carry_d = carry_i;
    if (take) begin
      carry_d.best_dist = cand_dist;
      carry_d.color     = color_i;
      carry_d.idx       = CELL_IDX;
    end
  end

  // Hand the result to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign valid_o = valid_q;
  assign carry_o = carry_q;

endmodule
`default_nettype wire

// ===== sv/nearest_palette_color_unit.sv =====
// Top level of the nearest palette color unit: register file and chain of search cells.
//
//  channel   signals                                    transfer when
//  -------   -----------------------------------------  ---------------------------
//  pixel in  start_i, busy_o, in_blue/green/red_i       start_i high, busy_o low
//  result    out_valid_o, out_blue/green/red_o,         out_valid_o high (one cycle)
//            chosen_entry_o
//  config    psel_i, penable_i, pwrite_i, paddr_i,      psel, penable, pready
//            pwdata_i, prdata_o, pready_o
//
// One pixel enters per cycle; each result leaves through the chain of cells,
// one registered cell per palette entry.
// busy_o stays low, so a pixel may be started on every cycle.
// Reset clears the pipeline valid bits, sets the count to one and the palette to zero.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Change the palette only while no pixel is in the chain.
`default_nettype none
module nearest_palette_color_unit #(
  parameter int unsigned PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [npc_pkg::CHAN_W-1:0]  in_blue_i,
  input  logic [npc_pkg::CHAN_W-1:0]  in_green_i,
  input  logic [npc_pkg::CHAN_W-1:0]  in_red_i,
  output logic                        out_valid_o,
  output logic [npc_pkg::CHAN_W-1:0]  out_blue_o,
  output logic [npc_pkg::CHAN_W-1:0]  out_green_o,
  output logic [npc_pkg::CHAN_W-1:0]  out_red_o,
  output logic [npc_pkg::IDX_W-1:0]   chosen_entry_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [npc_pkg::PADDR_W-1:0] paddr_i,
  input  logic [npc_pkg::PDATA_W-1:0] pwdata_i,
  output logic [npc_pkg::PDATA_W-1:0] prdata_o,
  output logic                        pready_o
);
  import npc_pkg::*;

  logic [COUNT_W-1:0] count;
  color_t             palette [8];
  logic               active  [PALETTE_ENTRIES];
  logic               valid   [PALETTE_ENTRIES+1];
  carry_t             carry   [PALETTE_ENTRIES+1];
  carry_t             head;

  npc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .count_o   (count),
    .palette_o (palette)
  );

  // Feed the pixel into the head of the chain.
  assign busy_o = 1'b0;
  assign valid[0] = start_i;
  always_comb begin
    head             = '0;
    head.pixel.blue  = in_blue_i;
    head.pixel.green = in_green_i;
    head.pixel.red   = in_red_i;
  end
  assign carry[0] = head;

  // One cell per searched entry; entry zero always takes part.
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign active[k] = 1'b1;
    end else begin : g_tail
      assign active[k] = (32'(count) > k);
    end

    npc_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[k]),
      .color_i  (palette[k]),
      .valid_i  (valid[k]),
      .carry_i  (carry[k]),
      .valid_o  (valid[k+1]),
      .carry_o  (carry[k+1])
    );
  end

  // Present the winner from the end of the chain.
  assign out_valid_o    = valid[PALETTE_ENTRIES];
  assign out_blue_o     = carry[PALETTE_ENTRIES].color.blue;
  assign out_green_o    = carry[PALETTE_ENTRIES].color.green;
  assign out_red_o      = carry[PALETTE_ENTRIES].color.red;
  assign chosen_entry_o = carry[PALETTE_ENTRIES].idx;

endmodule
`default_nettype wire

// ===== dv/nearest_palette_color_checker.sv =====
// Checker for the nearest palette color unit: register shadow, nearest-color predictor, compare.
module nearest_palette_color_checker
  import npc_pkg::*;
#(
  parameter int unsigned ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [CHAN_W-1:0]  in_blue_i,
  input  logic [CHAN_W-1:0]  in_green_i,
  input  logic [CHAN_W-1:0]  in_red_i,
  input  logic               out_valid_i,
  input  logic [CHAN_W-1:0]  out_blue_i,
  input  logic [CHAN_W-1:0]  out_green_i,
  input  logic [CHAN_W-1:0]  out_red_i,
  input  logic [IDX_W-1:0]   chosen_entry_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    color_t            color;
    logic [IDX_W-1:0]  entry;
  } nearest_t;

  // Shadow of the register file, kept from observed write transfers.
  logic [COUNT_W-1:0] count_q;
  logic [PAIR_W-1:0]  pair_q [NUM_PAIRS];

  // Nearest colors still owed by the block, oldest first.
  nearest_t quantized_q [$];

  // Squared difference of one channel.
  function automatic logic [DIST_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0]   d;
    logic [2*CHAN_W-1:0] sq;
    d  = (a > b) ? a - b : b - a;
    sq = d * d;
    return {{(DIST_W-2*CHAN_W){1'b0}}, sq};
  endfunction

  // Search the active entries; a strictly smaller distance is needed to replace the best.
  function automatic nearest_t nearest_of(input color_t px);
    nearest_t          best;
    color_t            c;
    logic [DIST_W-1:0] cand_dist;
    logic [DIST_W-1:0] best_dist;
    int unsigned       span;
    span = (count_q == '0) ? 1 : int'(count_q);
    if (span > ENTRIES) span = ENTRIES;
    best      = '0;
    best_dist = '0;
    for (int unsigned k = 0; k < span; k++) begin
      c         = color_t'(pair_q[k >> 1][(k & 1) * 24 +: 24]);
      cand_dist = chan_sq(px.blue, c.blue) + chan_sq(px.green, c.green)
                + chan_sq(px.red, c.red);
      if (k == 0 || cand_dist < best_dist) begin
        best_dist  = cand_dist;
        best.color = c;
        best.entry = IDX_W'(k);
      end
    end
    return best;
  endfunction

  task automatic report(input string what, input logic [PDATA_W-1:0] want,
                        input logic [PDATA_W-1:0] got);
    mismatches_o++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t           want;
    color_t             px;
    logic [2:0]         reg_id;
    logic [PDATA_W-1:0] reg_val;
    if (!rst_ni) begin
      count_q = COUNT_W'(1);
      for (int i = 0; i < NUM_PAIRS; i++) pair_q[i] = '0;
      quantized_q.delete();
      pending_o <= 0;
    end else begin
      reg_id = paddr_i[PADDR_W-1:3];
      // Track register writes; indexes past the last pair are dropped.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_id)
          REG_COUNT:  count_q = pwdata_i[COUNT_W-1:0];
          REG_PAIR_0,
          REG_PAIR_1,
          REG_PAIR_2,
          REG_PAIR_3: pair_q[reg_id - REG_PAIR_0] = pwdata_i[PAIR_W-1:0];
          default: ;
        endcase
      end
      // Check read data of the defined registers.
      if (psel_i && penable_i && !pwrite_i && pready_i && reg_id <= REG_PAIR_3) begin
        reg_val = '0;
        if (reg_id == REG_COUNT) reg_val[COUNT_W-1:0] = count_q;
        else reg_val[PAIR_W-1:0] = pair_q[reg_id - REG_PAIR_0];
        if (prdata_i !== reg_val) report("register read", reg_val, prdata_i);
      end
      // Predict on each pixel transfer.
      if (start_i && !busy_i) begin
        px.blue  = in_blue_i;
        px.green = in_green_i;
        px.red   = in_red_i;
        quantized_q.push_back(nearest_of(px));
      end
      // Compare each result with the oldest prediction.
      if (out_valid_i) begin
        if (quantized_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with nothing expected, actual %h/%h/%h entry %0d", $realtime,
                   out_red_i, out_green_i, out_blue_i, chosen_entry_i);
        end else begin
          want = quantized_q.pop_front();
          checked_o++;
          if (out_blue_i !== want.color.blue)
            report("out_blue", PDATA_W'(want.color.blue), PDATA_W'(out_blue_i));
          if (out_green_i !== want.color.green)
            report("out_green", PDATA_W'(want.color.green), PDATA_W'(out_green_i));
          if (out_red_i !== want.color.red)
            report("out_red", PDATA_W'(want.color.red), PDATA_W'(out_red_i));
          if (chosen_entry_i !== want.entry)
            report("chosen_entry", PDATA_W'(want.entry), PDATA_W'(chosen_entry_i));
        end
      end
      pending_o <= quantized_q.size();
    end
  end

  initial begin
    mismatches_o = 0;
    checked_o    = 0;
  end

endmodule

// ===== dv/nearest_palette_color_unit_tb.sv =====
// Testbench top for the nearest palette color unit: clock, reset, stimulus and verdict.
module nearest_palette_color_unit_tb
  import npc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES    = PALETTE_ENTRIES_DEF;
  localparam int          IDLE_LIMIT = 2000;
  // Register indexes past the last pair; writes there must be dropped.
  localparam logic [2:0] SPARE_REGS [3] = '{3'd5, 3'd6, 3'd7};
  localparam logic [2:0] REG_IDS [5] = '{REG_COUNT, REG_PAIR_0, REG_PAIR_1, REG_PAIR_2,
                                         REG_PAIR_3};

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [CHAN_W-1:0]  in_blue_i;
  logic [CHAN_W-1:0]  in_green_i;
  logic [CHAN_W-1:0]  in_red_i;
  logic               out_valid_o;
  logic [CHAN_W-1:0]  out_blue_o;
  logic [CHAN_W-1:0]  out_green_o;
  logic [CHAN_W-1:0]  out_red_o;
  logic [IDX_W-1:0]   chosen_entry_o;
  logic               psel_i;
  logic               penable_i;
  logic               pwrite_i;
  logic [PADDR_W-1:0] paddr_i;
  logic [PDATA_W-1:0] pwdata_i;
  logic [PDATA_W-1:0] prdata_o;
  logic               pready_o;

  int mismatches;
  int pending;
  int checked;

  nearest_palette_color_unit #(.PALETTE_ENTRIES(ENTRIES)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_blue_i, .in_green_i, .in_red_i,
    .out_valid_o, .out_blue_o, .out_green_o, .out_red_o, .chosen_entry_o,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  nearest_palette_color_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_blue_i, .in_green_i, .in_red_i,
    .out_valid_i(out_valid_o), .out_blue_i(out_blue_o), .out_green_i(out_green_o),
    .out_red_i(out_red_o), .chosen_entry_i(chosen_entry_o),
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_i(prdata_o),
    .pready_i(pready_o), .mismatches_o(mismatches), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register words last written: count, then the four pairs.
  logic [PDATA_W-1:0] reg_words [5];
  color_t             palette [8];
  int                 burst_left;
  int                 pixels_sent;
  int                 settings_used;
  int                 idle_cycles;

  // End the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_valid_o || (psel_i && penable_i && pready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic reg_access(input logic wr, input logic [2:0] id,
                            input logic [PDATA_W-1:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= PADDR_W'({id, 3'b000});
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all registers from reg_words (if asked), then read every one back.
  task automatic apply_registers(input logic wr);
    if (wr) begin
      for (int i = 0; i < 5; i++) reg_access(1'b1, REG_IDS[i], reg_words[i]);
      settings_used++;
    end
    for (int i = 0; i < 5; i++) reg_access(1'b0, REG_IDS[i], PDATA_W'($urandom()));
    for (int k = 0; k < 8; k++) palette[k] = color_t'(reg_words[1 + k / 2][(k % 2) * 24 +: 24]);
  endtask

  // Send one pixel; the sender works in bursts with random gaps between them.
  task automatic send_pixel(input color_t px);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    start_i    <= 1'b1;
    in_blue_i  <= px.blue;
    in_green_i <= px.green;
    in_red_i   <= px.red;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
    pixels_sent++;
  endtask

  // Hold off until every result is back and the search chain is empty.
  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (ENTRIES + 2) @(posedge clk_i);
  endtask

  // One palette channel: fully random, from a few values that give ties, or near a base.
  function automatic logic [CHAN_W-1:0] pick_channel(input int mode, input logic [7:0] base);
    case (mode)
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'h01;
          2: return 8'h80;
          default: return 8'hFF;
        endcase
      end
      2: return base + 8'($urandom_range(0, 8));
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    color_t      dir_px [10];
    color_t      px;
    logic [23:0] ent [2];
    logic [7:0]  base;
    int          mode;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_blue_i   = '0;
    in_green_i  = '0;
    in_red_i    = '0;
    psel_i      = 1'b0;
    penable_i   = 1'b0;
    pwrite_i    = 1'b0;
    paddr_i     = '0;
    pwdata_i    = '0;
    burst_left  = 0;
    pixels_sent = 0;
    settings_used = 0;
    idle_cycles = 0;
    reg_words   = '{64'd1, 64'd0, 64'd0, 64'd0, 64'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one black entry in use.
    apply_registers(1'b0);
    send_pixel(color_t'(24'h000000));
    send_pixel(color_t'(24'hFFFFFF));
    drain();

    // Full palette of extremes, with a duplicate entry; junk above the register widths.
    reg_words[0] = 64'hFFFF_FFFF_FFFF_FFF8;
    reg_words[1] = {16'hFFFF, 24'hFFFFFF, 24'h000000};
    reg_words[2] = {16'hA5A5, 24'h00FF00, 24'h0000FF};
    reg_words[3] = {16'h5A5A, 24'h808080, 24'hFF0000};
    reg_words[4] = {16'hFFFF, 24'h7F7F7F, 24'h808080};
    apply_registers(1'b1);
    dir_px = '{color_t'(24'h000000), color_t'(24'hFFFFFF), color_t'(24'h0000FF),
               color_t'(24'h00FF00), color_t'(24'hFF0000), color_t'(24'h808080),
               color_t'(24'h7F7F7F), color_t'(24'h404040), color_t'(24'h01FE80),
               color_t'(24'h7F8081)};
    foreach (dir_px[i]) send_pixel(dir_px[i]);
    drain();

    // Count of zero acts as one.
    reg_words[0] = 64'hFFFF_FFFF_FFFF_FFF0;
    apply_registers(1'b1);
    send_pixel(color_t'(24'hFFFFFF));
    send_pixel(color_t'(24'h808080));
    drain();

    // Count above the limit saturates.
    reg_words[0] = 64'd15;
    apply_registers(1'b1);
    send_pixel(color_t'(24'h7F7F7F));
    send_pixel(color_t'(24'hFF0000));
    drain();

    // Writes past the last register must leave everything unchanged.
    foreach (SPARE_REGS[i]) reg_access(1'b1, SPARE_REGS[i], '1);
    foreach (SPARE_REGS[i]) reg_access(1'b0, SPARE_REGS[i], '0);
    apply_registers(1'b0);
    send_pixel(color_t'(24'h808080));
    drain();

    // Equal distances pick the lower index, in both orders.
    reg_words[0] = 64'd2;
    reg_words[1] = {16'h0000, 24'h000002, 24'h000000};
    apply_registers(1'b1);
    send_pixel(color_t'(24'h000001));
    send_pixel(color_t'(24'h000003));
    drain();
    reg_words[1] = {16'h0000, 24'h000000, 24'h000002};
    apply_registers(1'b1);
    send_pixel(color_t'(24'h000001));
    drain();

    // Random palettes and counts; pixels random, near or at palette entries, or at corners.
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 3;
      base = 8'($urandom());
      if (ph == 0) reg_words[0] = 64'd8;
      else if ($urandom_range(0, 3) == 0) reg_words[0] = {$urandom(), $urandom()};
      else reg_words[0] = {$urandom(), 28'($urandom()), 4'($urandom_range(1, 8))};
      for (int p = 1; p < 5; p++) begin
        for (int e = 0; e < 2; e++)
          ent[e] = {pick_channel(mode, base), pick_channel(mode, base), pick_channel(mode, base)};
        reg_words[p] = {16'($urandom()), ent[1], ent[0]};
      end
      apply_registers(1'b1);
      repeat (110) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: px = color_t'(24'($urandom()));
          10, 11, 12, 13, 14, 15, 16: begin
            px = palette[$urandom_range(0, 7)];
            px.blue  = px.blue + 8'($urandom_range(0, 6)) - 8'd3;
            px.green = px.green + 8'($urandom_range(0, 6)) - 8'd3;
            px.red   = px.red + 8'($urandom_range(0, 6)) - 8'd3;
          end
          17, 18: px = palette[$urandom_range(0, 7)];
          default: px = color_t'({$urandom_range(0, 1) ? 8'hFF : 8'h00,
                                  $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                  $urandom_range(0, 1) ? 8'hFF : 8'h00});
        endcase
        send_pixel(px);
      end
      drain();
    end

    $display("Sent %0d pixels under %0d register settings; %0d results compared.",
             pixels_sent, settings_used, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== nearest_palette_color_unit.f =====
sv/npc_pkg.sv
sv/npc_regs.sv
sv/npc_cell.sv
sv/nearest_palette_color_unit.sv
dv/nearest_palette_color_checker.sv
dv/nearest_palette_color_unit_tb.sv
